>>> hdl/lsrc_pkg.sv
// ----------------------------------------------------------------------------
// lsrc_pkg
// Shared types and constants of the lamp strike and retry controller.
// ----------------------------------------------------------------------------
package lsrc_pkg;

    // register widths
    localparam int unsigned TIME_W  = 10;
    localparam int unsigned RETRY_W = 7;
    localparam int unsigned CFG_W   = 10;

    // register index codes
    typedef enum logic [1:0] {
        CFG_ON_TIME     = 2'd0,
        CFG_OFF_TIME    = 2'd1,
        CFG_RETRY_LIMIT = 2'd2,
        CFG_UNUSED      = 2'd3
    } t_cfg_idx;

    // item kind codes
    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_SET  = 1'b1
    } t_cmd;

    // clamp limits and reset values
    localparam logic [TIME_W-1:0]  ON_MIN    = 10'd10;
    localparam logic [TIME_W-1:0]  ON_MAX    = 10'd1000;
    localparam logic [TIME_W-1:0]  OFF_MIN   = 10'd10;
    localparam logic [TIME_W-1:0]  OFF_MAX   = 10'd1000;
    localparam logic [RETRY_W-1:0] RET_MIN   = 7'd1;
    localparam logic [RETRY_W-1:0] RET_MAX   = 7'd100;
    localparam logic [TIME_W-1:0]  ON_RESET  = 10'd990;
    localparam logic [TIME_W-1:0]  OFF_RESET = 10'd10;
    localparam logic [RETRY_W-1:0] RET_RESET = 7'd30;
    localparam logic [RETRY_W-1:0] RETRY_SAT = 7'd127;
    localparam logic [TIME_W-1:0]  ARM_TIME  = 10'd1;

    // one result item
    typedef struct packed {
        logic               drive;
        logic               target_on;
        logic               lit_confirmed;
        logic               strike_failed;
        logic [RETRY_W-1:0] retries_used;
    } t_result;

endpackage

>>> hdl/lsrc_core.sv
// ----------------------------------------------------------------------------
// lsrc_core
// Configuration registers, sequencer state and the next-state logic that
// turns one item into one result.
// ----------------------------------------------------------------------------
module lsrc_core #(
    parameter int unsigned TIMER_BITS = 10
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_index,
    input  logic [lsrc_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                       i_accept,
    input  logic                       i_cmd,
    input  logic                       i_target_request,
    input  logic                       i_lamp_sense,
    output lsrc_pkg::t_result          o_result
);
    import lsrc_pkg::*;

    // width wide enough for both a load value and the countdown
    localparam int unsigned LW = (TIMER_BITS > TIME_W) ? TIMER_BITS : TIME_W;
    localparam logic [LW-1:0] TIMER_MAX = LW'((64'd1 << TIMER_BITS) - 64'd1);

    // configuration
    logic [TIME_W-1:0]  r_on_time;
    logic [TIME_W-1:0]  r_off_time;
    logic [RETRY_W-1:0] r_retry_limit;

    // sequencer state
    logic                  r_target, n_target;
    logic                  r_phase_on, n_phase_on;
    logic [RETRY_W-1:0]    r_retry, n_retry;
    logic [TIMER_BITS-1:0] r_count, n_count;
    logic                  r_pending, n_pending;
    logic                  r_drive, n_drive;
    logic                  r_lit, n_lit;
    logic                  failed;
    logic [TIMER_BITS-1:0] count_dec;

    // saturate a load value to the countdown range
    function automatic logic [TIMER_BITS-1:0] sat_load(input logic [TIME_W-1:0] v);
        logic [LW-1:0] wide;
        wide = LW'(v);
        if (wide > TIMER_MAX) begin
            wide = TIMER_MAX;
        end
        return wide[TIMER_BITS-1:0];
    endfunction

    // clamped register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_time     <= ON_RESET;
            r_off_time    <= OFF_RESET;
            r_retry_limit <= RET_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ON_TIME: begin
                    if (i_cfg_data < ON_MIN)      r_on_time <= ON_MIN;
                    else if (i_cfg_data > ON_MAX) r_on_time <= ON_MAX;
                    else                          r_on_time <= i_cfg_data;
                end
                CFG_OFF_TIME: begin
                    if (i_cfg_data < OFF_MIN)      r_off_time <= OFF_MIN;
                    else if (i_cfg_data > OFF_MAX) r_off_time <= OFF_MAX;
                    else                           r_off_time <= i_cfg_data;
                end
                CFG_RETRY_LIMIT: begin
                    if (i_cfg_data[RETRY_W-1:0] < RET_MIN)      r_retry_limit <= RET_MIN;
                    else if (i_cfg_data[RETRY_W-1:0] > RET_MAX) r_retry_limit <= RET_MAX;
                    else r_retry_limit <= i_cfg_data[RETRY_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // countdown step
    assign count_dec = (r_count != '0) ? r_count - 1'b1 : '0;

    // next state for one item
    always_comb begin
        n_target   = r_target;
        n_phase_on = r_phase_on;
        n_retry    = r_retry;
        n_count    = r_count;
        n_pending  = r_pending;
        n_drive    = r_drive;
        n_lit      = r_lit;
        failed     = 1'b0;
        if (t_cmd'(i_cmd) == CMD_SET) begin
            // target change restarts the sequence
            if (i_target_request != r_target) begin
                n_target   = i_target_request;
                n_phase_on = 1'b0;
                n_retry    = '0;
                n_lit      = 1'b0;
                if (i_target_request) begin
                    n_count   = sat_load(ARM_TIME);
                    n_pending = 1'b1;
                end else begin
                    n_count   = '0;
                    n_pending = 1'b0;
                    n_drive   = 1'b0;
                end
            end
        end else if (r_pending) begin
            n_count = count_dec;
            if (count_dec == '0) begin
                // expiry
                if (i_lamp_sense && r_phase_on) begin
                    n_lit     = 1'b1;
                    n_pending = 1'b0;
                end else if (r_retry >= r_retry_limit || !r_target) begin
                    n_target  = 1'b0;
                    n_drive   = 1'b0;
                    n_pending = 1'b0;
                    failed    = 1'b1;
                end else begin
                    n_phase_on = !r_phase_on;
                    n_drive    = !r_phase_on;
                    n_count    = sat_load(r_phase_on ? r_off_time : r_on_time);
                    n_pending  = 1'b1;
                    if (r_phase_on && r_retry < RETRY_SAT) begin
                        n_retry = r_retry + 1'b1;
                    end
                end
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target   <= 1'b0;
            r_phase_on <= 1'b0;
            r_retry    <= '0;
            r_count    <= '0;
            r_pending  <= 1'b0;
            r_drive    <= 1'b0;
            r_lit      <= 1'b0;
        end else if (i_accept) begin
            r_target   <= n_target;
            r_phase_on <= n_phase_on;
            r_retry    <= n_retry;
            r_count    <= n_count;
            r_pending  <= n_pending;
            r_drive    <= n_drive;
            r_lit      <= n_lit;
        end
    end

    // result of this item
    always_comb begin
        o_result.drive         = n_drive;
        o_result.target_on     = n_target;
        o_result.lit_confirmed = n_lit;
        o_result.strike_failed = failed;
        o_result.retries_used  = n_retry;
    end

endmodule

>>> hdl/lamp_strike_retry_controller.sv
// ----------------------------------------------------------------------------
// lamp_strike_retry_controller
// Lamp ignition sequencer: strike attempts with on and off phases, feedback
// confirmation and a retry limit, one result item per input item.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                  | payload
//  in       | input     | i_in_valid / o_in_stall    | cmd, target_request, lamp_sense
//  out      | output    | o_out_valid / i_out_stall  | drive, target_on, lit_confirmed,
//           |           |                            | strike_failed, retries_used
//  cfg      | input     | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// one item per cycle while the skid is empty; its result is registered in the output buffer
// the sequencer next state and result logic are combinational
// a two-entry output buffer (result register plus skid) takes one more item
// while the output side stalls; the input stalls once the skid is full
// synchronous active-low reset clears state and loads register defaults
// ----------------------------------------------------------------------------
module lamp_strike_retry_controller #(
    parameter int unsigned TIMER_BITS = 10
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_index,
    input  logic [lsrc_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_cmd,
    input  logic                       i_target_request,
    input  logic                       i_lamp_sense,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_drive,
    output logic                       o_target_on,
    output logic                       o_lit_confirmed,
    output logic                       o_strike_failed,
    output logic [lsrc_pkg::RETRY_W-1:0] o_retries_used
);
    import lsrc_pkg::*;

    logic    accept;
    logic    out_take;
    t_result result;
    t_result r_out;
    t_result r_skd;
    logic    r_out_valid;
    logic    r_skd_valid;

    // handshakes
    assign o_in_stall = r_skd_valid;
    assign accept     = i_in_valid && !r_skd_valid;
    assign out_take   = r_out_valid && !i_out_stall;

    lsrc_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_accept         (accept),
        .i_cmd            (i_cmd),
        .i_target_request (i_target_request),
        .i_lamp_sense     (i_lamp_sense),
        .o_result         (result)
    );

    // output buffer valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (r_skd_valid) begin
            if (out_take) begin
                r_skd_valid <= 1'b0;
            end
        end else if (accept) begin
            if (r_out_valid && !out_take) begin
                r_skd_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    // output buffer payload
    always_ff @(posedge i_clk) begin
        if (r_skd_valid) begin
            if (out_take) begin
                r_out <= r_skd;
            end
        end else if (accept) begin
            if (r_out_valid && !out_take) begin
                r_skd <= result;
            end else begin
                r_out <= result;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_drive         = r_out.drive;
    assign o_target_on     = r_out.target_on;
    assign o_lit_confirmed = r_out.lit_confirmed;
    assign o_strike_failed = r_out.strike_failed;
    assign o_retries_used  = r_out.retries_used;

endmodule

>>> hdl/lsrc_checker.sv
// ----------------------------------------------------------------------------
// lsrc_checker
// Port-level checks on the result stream of the lamp strike controller.
// ----------------------------------------------------------------------------
module lsrc_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic                         o_drive,
    input logic                         o_target_on,
    input logic                         o_lit_confirmed,
    input logic                         o_strike_failed,
    input logic [lsrc_pkg::RETRY_W-1:0] o_retries_used
);
    import lsrc_pkg::*;

    // giving up always leaves the lamp off and the target dropped
    a_fail_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_strike_failed |-> !o_drive && !o_target_on)
        else $error("strike failure with drive or target still on");

    // a confirmed lamp is driven and targeted
    a_lit_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_lit_confirmed |-> o_drive && o_target_on)
        else $error("lit confirmed while drive or target off");

    // retries never run past the largest limit
    a_retry_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_retries_used <= RET_MAX)
        else $error("retry count beyond limit");

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_drive)
            && $stable(o_target_on) && $stable(o_lit_confirmed)
            && $stable(o_strike_failed) && $stable(o_retries_used))
        else $error("stalled result item changed");

endmodule

bind lamp_strike_retry_controller lsrc_checker u_lsrc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_drive         (o_drive),
    .o_target_on     (o_target_on),
    .o_lit_confirmed (o_lit_confirmed),
    .o_strike_failed (o_strike_failed),
    .o_retries_used  (o_retries_used)
);

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the lamp strike and retry controller. A directed
// drill walks reset behaviour, repeated commands, a full give-up and a lit
// confirmation. Random strike sequences then run under several register
// settings, including both clamp extremes. Every result item is checked field
// by field, against the drill row where that row is typed and otherwise against
// an in-bench model of the sequencer. Gaps and stalls are random on both channels.
// ----------------------------------------------------------------------------
module tb_top;

    import lsrc_pkg::*;

    localparam int unsigned TIMER_BITS = 10;
    localparam int          TIMER_TOP  = (1 << TIMER_BITS) - 1;
    localparam int          QUIET_MAX  = 3000;
    localparam int          SETTLE     = 4;

    // one row of the directed drill; want is used only where typed is set
    typedef struct packed {
        t_cmd     kind;
        logic     req;
        logic     sense;
        logic [3:0] reps;
        logic     typed;
        t_result  want;
    } t_drill_row;

    localparam int DRILL_ROWS = 23;
    localparam int STAGE_TWO  = 8;

    // want fields: drive, target_on, lit_confirmed, strike_failed, retries_used
    localparam t_drill_row DRILL [DRILL_ROWS] = '{
        // reset timings: idle ticks, repeated off, arm, first strike, cancel
        '{CMD_TICK, 1'b0, 1'b0, 4'd1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 7'd0}},
        '{CMD_TICK, 1'b0, 1'b1, 4'd1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 7'd0}},
        '{CMD_SET,  1'b0, 1'b0, 4'd1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 7'd0}},
        '{CMD_SET,  1'b1, 1'b1, 4'd1, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b0, 7'd0}},
        '{CMD_SET,  1'b1, 1'b0, 4'd1, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b0, 7'd0}},
        '{CMD_TICK, 1'b0, 1'b1, 4'd1, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 7'd0}},
        '{CMD_TICK, 1'b0, 1'b1, 4'd1, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 7'd0}},
        '{CMD_SET,  1'b0, 1'b1, 4'd1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 7'd0}},
        // lowest timings, one retry: strike, off phase, give up
        '{CMD_SET,  1'b1, 1'b0, 4'd1, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b0, 7'd0}},
        '{CMD_TICK, 1'b0, 1'b0, 4'd1, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 7'd0}},
        '{CMD_TICK, 1'b0, 1'b0, 4'd9, 1'b0, '0},
        '{CMD_TICK, 1'b0, 1'b0, 4'd1, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b0, 7'd1}},
        '{CMD_TICK, 1'b0, 1'b1, 4'd9, 1'b0, '0},
        '{CMD_TICK, 1'b0, 1'b1, 4'd1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 7'd1}},
        '{CMD_TICK, 1'b0, 1'b1, 4'd1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 7'd1}},
        '{CMD_SET,  1'b0, 1'b0, 4'd1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 7'd1}},
        // second attempt confirmed lit on the first on-phase expiry
        '{CMD_SET,  1'b1, 1'b0, 4'd1, 1'b1, '{1'b0, 1'b1, 1'b0, 1'b0, 7'd0}},
        '{CMD_TICK, 1'b0, 1'b0, 4'd1, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 7'd0}},
        '{CMD_TICK, 1'b0, 1'b1, 4'd9, 1'b0, '0},
        '{CMD_TICK, 1'b0, 1'b1, 4'd1, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 7'd0}},
        '{CMD_TICK, 1'b0, 1'b1, 4'd1, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 7'd0}},
        '{CMD_SET,  1'b1, 1'b0, 4'd1, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 7'd0}},
        '{CMD_SET,  1'b0, 1'b1, 4'd1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 7'd0}}
    };

    logic               clk            = 1'b0;
    logic               rst_n          = 1'b0;
    logic               cfg_we         = 1'b0;
    logic [1:0]         cfg_index      = CFG_ON_TIME;
    logic [CFG_W-1:0]   cfg_data       = '0;
    logic               in_valid       = 1'b0;
    logic               in_stall;
    logic               cmd            = CMD_TICK;
    logic               target_request = 1'b0;
    logic               lamp_sense     = 1'b0;
    logic               out_valid;
    logic               out_stall      = 1'b0;
    logic               drive;
    logic               target_on;
    logic               lit_confirmed;
    logic               strike_failed;
    logic [RETRY_W-1:0] retries_used;

    // typed expectation travelling with the item being offered
    logic    row_typed  = 1'b0;
    t_result row_expect = '0;

    // sequencer model state and its copy of the registers
    logic               lamp_target    = 1'b0;
    logic               lamp_phase_on  = 1'b0;
    logic               lamp_timer_run = 1'b0;
    logic               lamp_drive     = 1'b0;
    logic               lamp_lit       = 1'b0;
    logic [RETRY_W-1:0] lamp_retries   = '0;
    int                 lamp_timer     = 0;
    logic [TIME_W-1:0]  set_on_time    = ON_RESET;
    logic [TIME_W-1:0]  set_off_time   = OFF_RESET;
    logic [RETRY_W-1:0] set_retry_cap  = RET_RESET;

    t_result pending_q [$];
    int      mismatches   = 0;
    int      useful_items = 0;
    int      quiet        = 0;
    int      stall_run    = 0;
    int      flow_run     = 0;
    bit      sender_steady = 1'b0;
    int      sense_choice [3] = '{0, 3, 30};

    lamp_strike_retry_controller #(
        .TIMER_BITS(TIMER_BITS)
    ) i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_cmd            (cmd),
        .i_target_request (target_request),
        .i_lamp_sense     (lamp_sense),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_drive          (drive),
        .o_target_on      (target_on),
        .o_lit_confirmed  (lit_confirmed),
        .o_strike_failed  (strike_failed),
        .o_retries_used   (retries_used)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int clamp_range(int v, int lo, int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // register write as the block applies it, clamped to the legal range
    function automatic void cfg_apply(t_cfg_idx idx, logic [CFG_W-1:0] data);
        case (idx)
            CFG_ON_TIME: begin
                set_on_time = TIME_W'(clamp_range(int'(data), int'(ON_MIN), int'(ON_MAX)));
            end
            CFG_OFF_TIME: begin
                set_off_time = TIME_W'(clamp_range(int'(data), int'(OFF_MIN), int'(OFF_MAX)));
            end
            CFG_RETRY_LIMIT: begin
                set_retry_cap = RETRY_W'(clamp_range(int'(data[RETRY_W-1:0]),
                                                     int'(RET_MIN), int'(RET_MAX)));
            end
            default: ;
        endcase
    endfunction

    // load the countdown, saturating at the timer width
    function automatic void countdown_load(int ticks);
        lamp_timer     = (ticks > TIMER_TOP) ? TIMER_TOP : ticks;
        lamp_timer_run = 1'b1;
    endfunction

    // one item through the sequencer model; returns the result item it causes
    function automatic t_result ignition_step(t_cmd kind, logic req, logic sense);
        logic gave_up;
        gave_up = 1'b0;
        if (kind == CMD_SET) begin
            if (req != lamp_target) begin
                lamp_target   = req;
                lamp_phase_on = 1'b0;
                lamp_retries  = '0;
                lamp_lit      = 1'b0;
                if (req) begin
                    countdown_load(int'(ARM_TIME));
                end else begin
                    lamp_timer     = 0;
                    lamp_timer_run = 1'b0;
                    lamp_drive     = 1'b0;
                end
            end
        end else if (lamp_timer_run) begin
            if (lamp_timer != 0) lamp_timer--;
            if (lamp_timer == 0) begin
                if (sense && lamp_phase_on) begin
                    // feedback seen at the end of an on phase: lamp is lit
                    lamp_lit       = 1'b1;
                    lamp_timer_run = 1'b0;
                end else if (lamp_retries >= set_retry_cap || !lamp_target) begin
                    lamp_target    = 1'b0;
                    lamp_drive     = 1'b0;
                    lamp_timer_run = 1'b0;
                    gave_up        = 1'b1;
                end else begin
                    lamp_phase_on = !lamp_phase_on;
                    lamp_drive    = lamp_phase_on;
                    countdown_load(lamp_phase_on ? int'(set_on_time) : int'(set_off_time));
                    if (!lamp_phase_on && lamp_retries != RETRY_SAT) lamp_retries++;
                end
            end
        end
        return {lamp_drive, lamp_target, lamp_lit, gave_up, lamp_retries};
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // mostly short gaps, now and then a long one
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // offer one item and hold it until accepted
    task automatic send_item(t_cmd kind, logic req, logic sense, logic typed, t_result want);
        int gap;
        gap = sender_steady ? 0 : idle_length();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        cmd            <= kind;
        target_request <= req;
        lamp_sense     <= sense;
        row_typed      <= typed;
        row_expect     <= want;
        do @(posedge clk); while (in_stall);
    endtask

    // stop offering and wait until every result item is back
    task automatic wait_all_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_q.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // write all registers, the unused index last
    task automatic program_setting(logic [CFG_W-1:0] on_v, logic [CFG_W-1:0] off_v,
                                   logic [CFG_W-1:0] cap_v);
        logic [CFG_W-1:0] vals [4];
        vals = '{on_v, off_v, cap_v, CFG_W'($urandom)};
        for (int k = 0; k < 4; k++) begin
            cfg_we    <= 1'b1;
            cfg_index <= t_cfg_idx'(k);
            cfg_data  <= vals[k];
            @(posedge clk);
            cfg_apply(t_cfg_idx'(k), vals[k]);
        end
        cfg_we <= 1'b0;
    endtask

    // switch on, run ticks with random feedback, optionally switch off
    task automatic strike_sequence(int ticks, int sense_pct, bit cancel);
        sender_steady = ($urandom_range(0, 3) == 0);
        send_item(CMD_SET, 1'b1, 1'($urandom), 1'b0, '0);
        useful_items++;
        for (int k = 0; k < ticks; k++) begin
            if ($urandom_range(0, 99) < 6) begin
                send_item(t_cmd'($urandom_range(0, 1)), 1'($urandom), 1'($urandom), 1'b0, '0);
            end
            send_item(CMD_TICK, 1'($urandom), 1'($urandom_range(0, 99) < sense_pct), 1'b0, '0);
            useful_items++;
        end
        if (cancel) begin
            send_item(CMD_SET, 1'b0, 1'($urandom), 1'b0, '0);
            useful_items++;
        end
    endtask

    // strike sequences under the current setting: full runs, cut-offs, overlaps
    task automatic exercise_setting(int quota);
        int goal;
        int full;
        int r;
        goal = useful_items + quota;
        full = 1 + int'(set_retry_cap) * (int'(set_on_time) + int'(set_off_time));
        while (useful_items < goal) begin
            r = $urandom_range(0, 9);
            if (r < 5) begin
                strike_sequence(full + $urandom_range(0, 3), sense_choice[$urandom_range(0, 2)],
                                r < 2);
            end else begin
                strike_sequence($urandom_range(0, full), sense_choice[$urandom_range(0, 2)],
                                r < 8);
            end
            if ($urandom_range(0, 7) == 0) wait_all_results();
        end
    endtask

    // output side: random stall runs between stretches of free flow
    always @(posedge clk) begin
        if (flow_run == 0 && stall_run == 0) begin
            flow_run  = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                                    : $urandom_range(1, 6);
            stall_run = idle_length();
        end
        if (flow_run != 0) begin
            flow_run--;
            out_stall <= 1'b0;
        end else begin
            stall_run--;
            out_stall <= 1'b1;
        end
    end

    // predict on accept, compare on every result item
    always @(posedge clk) begin : result_check
        t_result got;
        t_result want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                got = {drive, target_on, lit_confirmed, strike_failed, retries_used};
                if (pending_q.size() == 0) begin
                    report_mismatch("result item with nothing expected");
                end else begin
                    want = pending_q.pop_front();
                    if (got.drive != want.drive)
                        report_mismatch($sformatf("drive exp %0b got %0b",
                                                  want.drive, got.drive));
                    if (got.target_on != want.target_on)
                        report_mismatch($sformatf("target_on exp %0b got %0b",
                                                  want.target_on, got.target_on));
                    if (got.lit_confirmed != want.lit_confirmed)
                        report_mismatch($sformatf("lit_confirmed exp %0b got %0b",
                                                  want.lit_confirmed, got.lit_confirmed));
                    if (got.strike_failed != want.strike_failed)
                        report_mismatch($sformatf("strike_failed exp %0b got %0b",
                                                  want.strike_failed, got.strike_failed));
                    if (got.retries_used != want.retries_used)
                        report_mismatch($sformatf("retries_used exp %0d got %0d",
                                                  want.retries_used, got.retries_used));
                end
            end
            if (in_valid && !in_stall) begin
                want = ignition_step(t_cmd'(cmd), target_request, lamp_sense);
                if (row_typed) want = row_expect;
                pending_q.push_back(want);
            end
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= QUIET_MAX) begin
            $display("lamp_strike_retry_controller verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed drill, reset timings first, then the lowest clamped ones
        for (int i = 0; i < DRILL_ROWS; i++) begin
            if (i == STAGE_TWO) begin
                wait_all_results();
                program_setting(10'd0, 10'd5, 10'd0);
            end
            for (int k = 0; k < int'(DRILL[i].reps); k++) begin
                send_item(DRILL[i].kind, DRILL[i].req, DRILL[i].sense,
                          DRILL[i].typed, DRILL[i].want);
            end
        end

        // random part: lowest clamp, small timings, top of the ranges, more small
        wait_all_results();
        program_setting(10'd0, 10'd0, 10'd0);
        exercise_setting(70);

        wait_all_results();
        program_setting(CFG_W'($urandom_range(10, 30)), CFG_W'($urandom_range(10, 30)),
                        CFG_W'($urandom_range(1, 3)));
        exercise_setting(70);

        // largest timings: one strike cut off early in its first on phase
        wait_all_results();
        program_setting(10'h3FF, 10'd1000, 10'd127);
        strike_sequence(40, 100, 1'b1);

        // upper bits of the retry limit write are dropped by the block
        wait_all_results();
        program_setting(CFG_W'($urandom_range(10, 25)), CFG_W'($urandom_range(10, 25)),
                        {3'($urandom), 7'($urandom_range(1, 3))});
        exercise_setting(70);

        wait_all_results();
        program_setting(CFG_W'($urandom_range(10, 20)), CFG_W'($urandom_range(10, 40)),
                        CFG_W'($urandom_range(2, 4)));
        exercise_setting(70);

        wait_all_results();
        if (mismatches == 0) begin
            $display("lamp_strike_retry_controller verification clean");
        end else begin
            $display("lamp_strike_retry_controller verification failed");
        end
        $finish;
    end

endmodule
